// File: design/dgm_pkg.sv
// Shared constants, types and codes for the detection gate merge block.
package dgm_pkg;

  // Store depth and derived index/count widths
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int GCNT_W      = $clog2(2 * MAX_ENTRIES + 2);

  // Field widths
  localparam int D_W   = 16;
  localparam int REQ_W = 2;
  localparam int RAD_W = 34;
  localparam int SQ_W  = 32;

  // Squared gate after reset: 0.25 m^2 in Q.16
  localparam logic [RAD_W-1:0] GATE_RESET = RAD_W'(16384);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CAM   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LID   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MERGE = 2'd2;

  // Lidar entry held in one cell
  typedef struct packed {
    logic [D_W-1:0]        id;
    logic signed [D_W-1:0] x;
    logic signed [D_W-1:0] y;
  } lid_ent_t;

  // Camera entry held in the camera memory
  typedef struct packed {
    logic [D_W-1:0]        id;
    logic signed [D_W-1:0] x;
    logic signed [D_W-1:0] y;
    logic signed [D_W-1:0] vx;
    logic signed [D_W-1:0] vy;
  } cam_ent_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: design/detection_gate_merge.sv
// Top level: camera memory, lidar cell chain, merge sequencer and output register.
// Load word: accepted back to back while idle; loads into a full store are dropped.
// Merge word: gating runs while the C camera words (C camera entries) march through the lidar
//   cell chain; then each camera result is read and sent in turn (one memory read port), then
//   the lidar cells are shifted out of the chain head, and the sequencer finishes back in idle.
// Input stalls for the whole merge; results leave through one output register.
// Reset (synchronous, rst_n low): counts and alive bits zero, gate 16384, idle; stores hold junk.
module detection_gate_merge import dgm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [RAD_W-1:0]      cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [D_W-1:0]        in_obj_id,
  input  logic signed [D_W-1:0] in_pos_x,
  input  logic signed [D_W-1:0] in_pos_y,
  input  logic signed [D_W-1:0] in_vel_x,
  input  logic signed [D_W-1:0] in_vel_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [D_W-1:0]        out_id,
  output logic signed [D_W-1:0] out_x,
  output logic signed [D_W-1:0] out_y,
  output logic signed [D_W-1:0] out_vx,
  output logic signed [D_W-1:0] out_vy,
  output logic                  out_from_lidar,
  output logic                  out_last
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_GATE    = 3'd1;
  localparam logic [2:0] ST_CAM_RD  = 3'd2;
  localparam logic [2:0] ST_CAM_OUT = 3'd3;
  localparam logic [2:0] ST_LID     = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [GCNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cam_cnt_r, cam_cnt_nxt;
  logic [CNT_W-1:0]  lid_cnt_r, lid_cnt_nxt;
  logic [RAD_W-1:0]  gate_sq_r;
  logic              tok_vld_r, tok_vld_nxt;

  cam_ent_t          cam_mem [MAX_ENTRIES];
  cam_ent_t          cam_rd_r;
  cam_ent_t          cam_wr;
  logic              cam_we;

  logic              in_acc, slot_free;
  logic              cam_full, lid_full;
  logic              cam_last;
  logic [GCNT_W-1:0] gate_end;
  logic              lid_ld;
  logic              chain_shift;
  logic              out_load, out_sel_lid, out_last_v;

  // Chain wiring; index MAX_ENTRIES is the empty fill past the tail
  logic signed [D_W-1:0]  tok_x   [MAX_ENTRIES+1];
  logic signed [D_W-1:0]  tok_y   [MAX_ENTRIES+1];
  logic                   tok_vld [MAX_ENTRIES+1];
  logic                   match   [MAX_ENTRIES+1];
  lid_ent_t               ent     [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0]   alive_vec;
  cell_ctrl_t             cell_ctrl [MAX_ENTRIES];
  lid_ent_t               ld_ent;
  logic                   any_alive, tail_alive;

  logic              out_valid_r;
  logic [D_W-1:0]    out_id_r;
  logic signed [D_W-1:0] out_x_r, out_y_r, out_vx_r, out_vy_r;
  logic              out_from_lidar_r, out_last_r;

  // Handshake helpers
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cam_full  = (cam_cnt_r == CNT_W'(MAX_ENTRIES));
  assign lid_full  = (lid_cnt_r == CNT_W'(MAX_ENTRIES));
  assign cam_last  = (cnt_r == (GCNT_W'(cam_cnt_r) - GCNT_W'(1)));
  assign gate_end  = GCNT_W'(cam_cnt_r) + GCNT_W'(MAX_ENTRIES);
  assign lid_ld    = in_acc && (in_req_type == REQ_LID) && !lid_full;

  assign any_alive  = |alive_vec[MAX_ENTRIES-1:0];
  assign tail_alive = |(alive_vec[MAX_ENTRIES-1:0] >> 1);

  // Gate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_sq_r <= GATE_RESET;
    end else if (cfg_wr_en) begin
      gate_sq_r <= cfg_wr_data;
    end
  end

  // Merge sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cam_cnt_nxt = cam_cnt_r;
    lid_cnt_nxt = lid_cnt_r;
    cam_we      = 1'b0;
    chain_shift = 1'b0;
    out_load    = 1'b0;
    out_sel_lid = 1'b0;
    out_last_v  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_type)
            REQ_CAM: begin
              if (!cam_full) begin
                cam_we      = 1'b1;
                cam_cnt_nxt = cam_cnt_r + CNT_W'(1);
              end
            end
            REQ_LID: begin
              if (!lid_full) begin
                lid_cnt_nxt = lid_cnt_r + CNT_W'(1);
              end
            end
            REQ_MERGE: begin
              state_nxt = ST_GATE;
              cnt_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_GATE: begin
        cnt_nxt = cnt_r + GCNT_W'(1);
        if (cnt_r == gate_end) begin
          cnt_nxt   = '0;
          state_nxt = (cam_cnt_r == '0) ? ST_LID : ST_CAM_RD;
        end
      end
      ST_CAM_RD: begin
        state_nxt = ST_CAM_OUT;
      end
      ST_CAM_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_last_v = cam_last && !any_alive;
          if (cam_last) begin
            state_nxt = ST_LID;
          end else begin
            cnt_nxt   = cnt_r + GCNT_W'(1);
            state_nxt = ST_CAM_RD;
          end
        end
      end
      ST_LID: begin
        if (!any_alive) begin
          state_nxt   = ST_IDLE;
          cam_cnt_nxt = '0;
          lid_cnt_nxt = '0;
        end else if (alive_vec[0]) begin
          if (slot_free) begin
            out_load    = 1'b1;
            out_sel_lid = 1'b1;
            out_last_v  = !tail_alive;
            chain_shift = 1'b1;
          end
        end else begin
          chain_shift = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign tok_vld_nxt = (state_r == ST_GATE) && (cnt_r < GCNT_W'(cam_cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      cam_cnt_r <= '0;
      lid_cnt_r <= '0;
      tok_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cam_cnt_r <= cam_cnt_nxt;
      lid_cnt_r <= lid_cnt_nxt;
      tok_vld_r <= tok_vld_nxt;
    end
  end

  // Camera memory: write on load, registered read at the sequencer count
  assign cam_wr = '{id: in_obj_id, x: in_pos_x, y: in_pos_y, vx: in_vel_x, vy: in_vel_y};

  always_ff @(posedge clk) begin
    if (cam_we) begin
      cam_mem[cam_cnt_r[IDX_W-1:0]] <= cam_wr;
    end
    cam_rd_r <= cam_mem[cnt_r[IDX_W-1:0]];
  end

  // Lidar cell chain
  assign ld_ent   = '{id: in_obj_id, x: in_pos_x, y: in_pos_y};
  assign tok_x[0]   = cam_rd_r.x;
  assign tok_y[0]   = cam_rd_r.y;
  assign tok_vld[0] = tok_vld_r;
  assign match[0]   = 1'b0;
  assign ent[MAX_ENTRIES]       = '0;
  assign alive_vec[MAX_ENTRIES] = 1'b0;

  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    assign cell_ctrl[j].load  = lid_ld && (lid_cnt_r == CNT_W'(j));
    assign cell_ctrl[j].shift = chain_shift;

    dgm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl[j]),
      .ld_ent    (ld_ent),
      .nb_ent    (ent[j+1]),
      .nb_alive  (alive_vec[j+1]),
      .tok_x_i   (tok_x[j]),
      .tok_y_i   (tok_y[j]),
      .tok_vld_i (tok_vld[j]),
      .match_i   (match[j]),
      .gate_sq   (gate_sq_r),
      .tok_x_o   (tok_x[j+1]),
      .tok_y_o   (tok_y[j+1]),
      .tok_vld_o (tok_vld[j+1]),
      .match_o   (match[j+1]),
      .ent_o     (ent[j]),
      .alive_o   (alive_vec[j])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id_r         <= out_sel_lid ? ent[0].id : cam_rd_r.id;
      out_x_r          <= out_sel_lid ? ent[0].x  : cam_rd_r.x;
      out_y_r          <= out_sel_lid ? ent[0].y  : cam_rd_r.y;
      out_vx_r         <= out_sel_lid ? '0 : cam_rd_r.vx;
      out_vy_r         <= out_sel_lid ? '0 : cam_rd_r.vy;
      out_from_lidar_r <= out_sel_lid;
      out_last_r       <= out_last_v;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_id         = out_id_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_vx         = out_vx_r;
  assign out_vy         = out_vy_r;
  assign out_from_lidar = out_from_lidar_r;
  assign out_last       = out_last_r;

  // Checks
  a_merge_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_MERGE) |=> in_stall)
    else $error("merge word did not block the input");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cam_cnt_r <= CNT_W'(MAX_ENTRIES)) && (lid_cnt_r <= CNT_W'(MAX_ENTRIES)))
    else $error("store count beyond depth");

  a_idle_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && any_alive |-> (lid_cnt_r != '0))
    else $error("live lidar cell with empty lidar count");

  a_lid_shift_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_sel_lid |-> chain_shift && (state_r == ST_LID))
    else $error("lidar word sent without shifting the chain");

endmodule

// File: design/dgm_cell.sv
// One lidar cell: holds an entry, gates passing camera words, shifts toward the head.
module dgm_cell import dgm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctrl_t              ctrl,
  input  lid_ent_t                ld_ent,
  input  lid_ent_t                nb_ent,
  input  logic                    nb_alive,
  input  logic signed [D_W-1:0]   tok_x_i,
  input  logic signed [D_W-1:0]   tok_y_i,
  input  logic                    tok_vld_i,
  input  logic                    match_i,
  input  logic [RAD_W-1:0]        gate_sq,
  output logic signed [D_W-1:0]   tok_x_o,
  output logic signed [D_W-1:0]   tok_y_o,
  output logic                    tok_vld_o,
  output logic                    match_o,
  output lid_ent_t                ent_o,
  output logic                    alive_o
);

  lid_ent_t                ent_r;
  logic                    alive_r, alive_nxt;
  logic signed [D_W-1:0]   tok_x_r, tok_y_r;
  logic                    tok_vld_r;
  logic                    pend_r;
  logic                    match_r, match_nxt;
  logic [SQ_W-1:0]         sqx_r, sqy_r;
  logic signed [D_W:0]     dx, dy;
  logic signed [2*D_W+1:0] sqx_full, sqy_full;
  logic [RAD_W-1:0]        sum_sq;
  logic                    hit;

  // Stage 1: differences and squares against the held lidar position
  assign dx       = {tok_x_i[D_W-1], tok_x_i} - {ent_r.x[D_W-1], ent_r.x};
  assign dy       = {tok_y_i[D_W-1], tok_y_i} - {ent_r.y[D_W-1], ent_r.y};
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  always_ff @(posedge clk) begin
    sqx_r   <= sqx_full[SQ_W-1:0];
    sqy_r   <= sqy_full[SQ_W-1:0];
    tok_x_r <= tok_x_i;
    tok_y_r <= tok_y_i;
  end

  // Stage 2: sum, compare and claim this entry if the word is still unmatched
  assign sum_sq = {2'b00, sqx_r} + {2'b00, sqy_r};
  assign hit    = pend_r && !match_i && alive_r && (sum_sq <= gate_sq);
  assign match_nxt = match_i || hit;

  // Alive bit: load, shift toward head, or drop on a gate hit
  always_comb begin
    alive_nxt = alive_r;
    if (ctrl.load) begin
      alive_nxt = 1'b1;
    end else if (ctrl.shift) begin
      alive_nxt = nb_alive;
    end else if (hit) begin
      alive_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r   <= 1'b0;
      tok_vld_r <= 1'b0;
      pend_r    <= 1'b0;
      match_r   <= 1'b0;
    end else begin
      alive_r   <= alive_nxt;
      tok_vld_r <= tok_vld_i;
      pend_r    <= tok_vld_i;
      match_r   <= match_nxt;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ent_r <= ld_ent;
    end else if (ctrl.shift) begin
      ent_r <= nb_ent;
    end
  end

  assign tok_x_o   = tok_x_r;
  assign tok_y_o   = tok_y_r;
  assign tok_vld_o = tok_vld_r;
  assign match_o   = match_r;
  assign ent_o     = ent_r;
  assign alive_o   = alive_r;

endmodule
